// ===== sv/gcx_pkg.sv =====
// ============================================================================
// gcx_pkg: shared types and constants for the glyph color expansion blitter
// Widths, geometry constants, register indexes and the command format
// passed from the byte classifier to the pixel writer.
// ============================================================================
package gcx_pkg;

    localparam int unsigned ROW_STRIDE_BYTES = 8192;
    localparam int unsigned MAX_GLYPH_DIM    = 64;
    localparam int unsigned PIX_BYTES        = 4;

    localparam int unsigned ADDR_W   = 24;
    localparam int unsigned COLOR_W  = 32;
    localparam int unsigned POS_W    = 11;
    localparam int unsigned DIM_W    = 7;
    localparam int unsigned SCREEN_W = 12;
    localparam int unsigned ROW_W    = 6;
    localparam int unsigned BCOL_W   = 3;
    localparam int unsigned LANES    = 8;
    localparam int unsigned LANE_W   = 3;
    localparam int unsigned NBYTE_W  = 4;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 12;

    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_SCREEN_HEIGHT = 2'd1;

    localparam logic [SCREEN_W-1:0] SCREEN_WIDTH_RST  = 12'd1024;
    localparam logic [SCREEN_W-1:0] SCREEN_HEIGHT_RST = 12'd768;

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = 2;

    // One source byte that produces at least one pixel write.
    typedef struct packed {
        logic [ADDR_W-1:0]  base_addr;
        logic [LANES-1:0]   write_mask;
        logic [LANES-1:0]   glyph_bits;
        logic [COLOR_W-1:0] fg_color;
        logic [COLOR_W-1:0] bg_color;
    } gcx_cmd_t;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QPTR_W:0]   count;
    } gcx_q_status_t;

    typedef struct packed {
        logic busy;
        logic last;
    } gcx_back_status_t;

endpackage

// ===== sv/gcx_src_if.sv =====
// ============================================================================
// gcx_src_if: source byte channel
// Valid/ready channel carrying one glyph source byte and its context.
// ============================================================================
interface gcx_src_if;
    logic                          valid;
    logic                          ready;
    logic                          first_of_glyph;
    logic [7:0]                    glyph_bits;
    logic [7:0]                    mask_bits;
    logic                          use_mask;
    logic [gcx_pkg::POS_W-1:0]     top_line;
    logic [gcx_pkg::POS_W-1:0]     left_column;
    logic [gcx_pkg::DIM_W-1:0]     glyph_width;
    logic [gcx_pkg::DIM_W-1:0]     glyph_height;
    logic [gcx_pkg::COLOR_W-1:0]   fg_color;
    logic [gcx_pkg::COLOR_W-1:0]   bg_color;

    modport source (
        output valid, first_of_glyph, glyph_bits, mask_bits, use_mask,
               top_line, left_column, glyph_width, glyph_height, fg_color, bg_color,
        input  ready
    );
    modport sink (
        input  valid, first_of_glyph, glyph_bits, mask_bits, use_mask,
               top_line, left_column, glyph_width, glyph_height, fg_color, bg_color,
        output ready
    );
endinterface

// ===== sv/gcx_dst_if.sv =====
// ============================================================================
// gcx_dst_if: pixel write channel
// Valid/ready channel carrying one 32-bit framebuffer pixel write.
// ============================================================================
interface gcx_dst_if;
    logic                          valid;
    logic                          ready;
    logic [gcx_pkg::ADDR_W-1:0]    pixel_address;
    logic [gcx_pkg::COLOR_W-1:0]   pixel_value;
    logic                          last_of_byte;

    modport source (
        output valid, pixel_address, pixel_value, last_of_byte,
        input  ready
    );
    modport sink (
        input  valid, pixel_address, pixel_value, last_of_byte,
        output ready
    );
endinterface

// ===== sv/gcx_front.sv =====
// ============================================================================
// gcx_front: byte classifier
// Holds the screen size registers and the row/byte-column counters, decides
// which pixels of each byte are written and builds the row base address.
// ============================================================================
module gcx_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [gcx_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [gcx_pkg::CFG_DATA_W-1:0]    cfg_data,
    gcx_src_if.sink                           src,
    input  logic                              q_full,
    output logic                              q_push,
    output gcx_pkg::gcx_cmd_t                 q_cmd
);

    logic [gcx_pkg::SCREEN_W-1:0] screen_width_reg, screen_width_next;
    logic [gcx_pkg::SCREEN_W-1:0] screen_height_reg, screen_height_next;
    logic [gcx_pkg::ROW_W-1:0]    row_reg, row_next;
    logic [gcx_pkg::BCOL_W-1:0]   bcol_reg, bcol_next;

    logic [gcx_pkg::ROW_W-1:0]    row_eff;
    logic [gcx_pkg::BCOL_W-1:0]   bcol_eff;
    logic                         accept;
    logic                         size_bad;
    logic                         fits_h;
    logic                         fits_v;
    logic                         row_ok;
    logic                         emit;
    logic [gcx_pkg::LANES-1:0]    wmask;
    logic [gcx_pkg::DIM_W-1:0]    col_base;
    logic [gcx_pkg::SCREEN_W-1:0] line_sum;
    logic [gcx_pkg::SCREEN_W-1:0] pix_col;
    logic [gcx_pkg::ADDR_W-1:0]   line_addr;
    logic [gcx_pkg::NBYTE_W-1:0]  nbytes;
    logic                         last_col;

    assign src.ready = !q_full;
    assign accept    = src.valid && src.ready;

    assign row_eff  = src.first_of_glyph ? '0 : row_reg;
    assign bcol_eff = src.first_of_glyph ? '0 : bcol_reg;

    assign size_bad = (src.glyph_width == '0)
                   || (src.glyph_width > gcx_pkg::DIM_W'(gcx_pkg::MAX_GLYPH_DIM))
                   || (src.glyph_height == '0)
                   || (src.glyph_height > gcx_pkg::DIM_W'(gcx_pkg::MAX_GLYPH_DIM));

    assign fits_h = (gcx_pkg::SCREEN_W'(src.left_column)
                     + gcx_pkg::SCREEN_W'(src.glyph_width)) <= screen_width_reg;
    assign fits_v = (gcx_pkg::SCREEN_W'(src.top_line)
                     + gcx_pkg::SCREEN_W'(src.glyph_height)) <= screen_height_reg;
    assign row_ok = gcx_pkg::DIM_W'(row_eff) < src.glyph_height;
    assign emit   = !size_bad && fits_h && fits_v && row_ok;

    assign col_base = gcx_pkg::DIM_W'({bcol_eff, 3'b000});

    // Bit 7 is the leftmost pixel; lane k covers glyph column col_base + k.
    always_comb
    begin
        for (int k = 0; k < gcx_pkg::LANES; k++)
        begin
            wmask[gcx_pkg::LANES-1-k] =
                ((col_base + gcx_pkg::DIM_W'(k)) < src.glyph_width)
                && (!src.use_mask || src.mask_bits[gcx_pkg::LANES-1-k]);
        end
    end

    assign line_sum  = gcx_pkg::SCREEN_W'(src.top_line) + gcx_pkg::SCREEN_W'(row_eff);
    assign pix_col   = gcx_pkg::SCREEN_W'(src.left_column) + gcx_pkg::SCREEN_W'(col_base);
    assign line_addr = gcx_pkg::ADDR_W'(line_sum * gcx_pkg::ROW_STRIDE_BYTES);

    assign q_cmd.base_addr  = line_addr
                            + gcx_pkg::ADDR_W'(pix_col * gcx_pkg::PIX_BYTES);
    assign q_cmd.write_mask = wmask;
    assign q_cmd.glyph_bits = src.glyph_bits;
    assign q_cmd.fg_color   = src.fg_color;
    assign q_cmd.bg_color   = src.bg_color;

    assign q_push = accept && emit && (wmask != '0);

    assign nbytes   = gcx_pkg::NBYTE_W'((8'(src.glyph_width) + 8'd7) >> 3);
    assign last_col = (gcx_pkg::NBYTE_W'(bcol_eff) + gcx_pkg::NBYTE_W'(1)) >= nbytes;

    always_comb
    begin
        row_next  = row_reg;
        bcol_next = bcol_reg;
        if (accept)
        begin
            priority if (size_bad)
            begin
                row_next  = '0;
                bcol_next = '0;
            end
            else if (last_col)
            begin
                row_next  = row_eff + gcx_pkg::ROW_W'(1);
                bcol_next = '0;
            end
            else
            begin
                row_next  = row_eff;
                bcol_next = bcol_eff + gcx_pkg::BCOL_W'(1);
            end
        end
    end

    always_comb
    begin
        screen_width_next  = screen_width_reg;
        screen_height_next = screen_height_reg;
        if (cfg_we)
        begin
            if (cfg_index == gcx_pkg::CFG_IDX_SCREEN_WIDTH)
            begin
                screen_width_next = gcx_pkg::SCREEN_W'(cfg_data);
            end
            if (cfg_index == gcx_pkg::CFG_IDX_SCREEN_HEIGHT)
            begin
                screen_height_next = gcx_pkg::SCREEN_W'(cfg_data);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= gcx_pkg::SCREEN_WIDTH_RST;
            screen_height_reg <= gcx_pkg::SCREEN_HEIGHT_RST;
            row_reg           <= '0;
            bcol_reg          <= '0;
        end
        else
        begin
            screen_width_reg  <= screen_width_next;
            screen_height_reg <= screen_height_next;
            row_reg           <= row_next;
            bcol_reg          <= bcol_next;
        end
    end

endmodule

// ===== sv/gcx_cmd_fifo.sv =====
// ============================================================================
// gcx_cmd_fifo: command queue
// Small register FIFO that decouples the classifier from the pixel writer.
// ============================================================================
module gcx_cmd_fifo (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  gcx_pkg::gcx_cmd_t       push_cmd,
    input  logic                    pop,
    output gcx_pkg::gcx_cmd_t       pop_cmd,
    output gcx_pkg::gcx_q_status_t  status
);

    gcx_pkg::gcx_cmd_t            mem_reg [gcx_pkg::QDEPTH];
    logic [gcx_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [gcx_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [gcx_pkg::QPTR_W:0]     count_reg, count_next;
    logic                         do_push;
    logic                         do_pop;

    assign status.full  = count_reg == (gcx_pkg::QPTR_W+1)'(gcx_pkg::QDEPTH);
    assign status.empty = count_reg == '0;
    assign status.count = count_reg;

    assign do_push = push && !status.full;
    assign do_pop  = pop && !status.empty;
    assign pop_cmd = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + gcx_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + gcx_pkg::QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg
                    + (gcx_pkg::QPTR_W+1)'(do_push)
                    - (gcx_pkg::QPTR_W+1)'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== sv/gcx_back.sv =====
// ============================================================================
// gcx_back: pixel writer
// Walks the write mask of one command left to right and issues one pixel
// write per cycle while dst accepts, through a registered output stage.
// ============================================================================
module gcx_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_valid,
    input  gcx_pkg::gcx_cmd_t         q_cmd,
    output logic                      q_pop,
    output gcx_pkg::gcx_back_status_t status,
    gcx_dst_if.source                 dst
);

    logic [gcx_pkg::LANES-1:0]    mask_reg, mask_next;
    logic [gcx_pkg::ADDR_W-1:0]   base_reg, base_next;
    logic [gcx_pkg::LANES-1:0]    gbits_reg, gbits_next;
    logic [gcx_pkg::COLOR_W-1:0]  fg_reg, fg_next;
    logic [gcx_pkg::COLOR_W-1:0]  bg_reg, bg_next;

    logic                         out_valid_reg, out_valid_next;
    logic [gcx_pkg::ADDR_W-1:0]   out_addr_reg, out_addr_next;
    logic [gcx_pkg::COLOR_W-1:0]  out_value_reg, out_value_next;
    logic                         out_last_reg, out_last_next;

    logic                         busy;
    logic                         out_free;
    logic                         advance;
    logic [gcx_pkg::LANE_W-1:0]   sel_k;
    logic [gcx_pkg::LANE_W-1:0]   sel_bit;
    logic [gcx_pkg::LANES-1:0]    remaining;
    logic                         last;

    assign busy     = mask_reg != '0;
    assign out_free = !out_valid_reg || dst.ready;
    assign advance  = busy && out_free;

    // Leftmost pending pixel: lane k sits at mask bit 7-k.
    always_comb
    begin
        sel_k = '0;
        for (int k = gcx_pkg::LANES - 1; k >= 0; k--)
        begin
            if (mask_reg[gcx_pkg::LANES-1-k])
            begin
                sel_k = gcx_pkg::LANE_W'(k);
            end
        end
    end

    assign sel_bit = gcx_pkg::LANE_W'(gcx_pkg::LANES - 1) - sel_k;

    always_comb
    begin
        remaining          = mask_reg;
        remaining[sel_bit] = 1'b0;
    end

    assign last  = remaining == '0;
    assign q_pop = q_valid && (!busy || (advance && last));

    assign status.busy = busy;
    assign status.last = last;

    always_comb
    begin
        mask_next  = mask_reg;
        base_next  = base_reg;
        gbits_next = gbits_reg;
        fg_next    = fg_reg;
        bg_next    = bg_reg;
        if (q_pop)
        begin
            mask_next  = q_cmd.write_mask;
            base_next  = q_cmd.base_addr;
            gbits_next = q_cmd.glyph_bits;
            fg_next    = q_cmd.fg_color;
            bg_next    = q_cmd.bg_color;
        end
        else if (advance)
        begin
            mask_next = remaining;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_addr_next  = out_addr_reg;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
            out_addr_next  = base_reg
                           + gcx_pkg::ADDR_W'(sel_k) * gcx_pkg::ADDR_W'(gcx_pkg::PIX_BYTES);
            out_value_next = gbits_reg[sel_bit] ? fg_reg : bg_reg;
            out_last_next  = last;
        end
        else if (dst.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign dst.valid         = out_valid_reg;
    assign dst.pixel_address = out_addr_reg;
    assign dst.pixel_value   = out_value_reg;
    assign dst.last_of_byte  = out_last_reg;

    always_ff @(posedge clk)
    begin
        base_reg      <= base_next;
        gbits_reg     <= gbits_next;
        fg_reg        <= fg_next;
        bg_reg        <= bg_next;
        out_addr_reg  <= out_addr_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== sv/glyph_color_expansion_blit_core.sv =====
// ============================================================================
// glyph_color_expansion_blit_core: monochrome glyph to 32-bit pixel writes
// Expands glyph source bytes into foreground/background pixel writes.
// ============================================================================
//
//  Port      Dir   Kind         Carries
//  src       in    valid/ready  one glyph source byte with position, size, colors
//  dst       out   valid/ready  one pixel write: address, value, last_of_byte
//  cfg_*     in    write only   screen width (index 0), screen height (index 1)
//
// The pixel writer issues one pixel write per cycle while dst is ready, so a
// byte that writes n pixels (up to 8) holds it for n writes; bytes that write
// nothing are never queued. A four-entry command queue lets the classifier
// keep taking bytes while the writer drains. A first write passes through the
// queue, mask and output registers. Reset restores the screen size and clears
// the counters; no clearing pass is needed. A stalled dst holds its beat.
//
module glyph_color_expansion_blit_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [gcx_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [gcx_pkg::CFG_DATA_W-1:0]    cfg_data,
    gcx_src_if.sink                           src,
    gcx_dst_if.source                         dst
);

    logic                      q_push;
    logic                      q_pop;
    gcx_pkg::gcx_cmd_t         push_cmd;
    gcx_pkg::gcx_cmd_t         pop_cmd;
    gcx_pkg::gcx_q_status_t    q_status;
    gcx_pkg::gcx_back_status_t back_status;

    gcx_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .src       (src),
        .q_full    (q_status.full),
        .q_push    (q_push),
        .q_cmd     (push_cmd)
    );

    gcx_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd),
        .status   (q_status)
    );

    gcx_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (!q_status.empty),
        .q_cmd   (pop_cmd),
        .q_pop   (q_pop),
        .status  (back_status),
        .dst     (dst)
    );

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_status.full)
        else $error("command pushed into a full queue");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_status.empty)
        else $error("command popped from an empty queue");

    a_pop_loads_work: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> back_status.busy)
        else $error("popped command carried no pixel writes");

    a_idle_no_new_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (!back_status.busy && !dst.valid) |=> !dst.valid)
        else $error("pixel write issued with no command in progress");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ============================================================================
// testbench: glyph color expansion blitter
// Drives glyph source bytes through the src channel and checks every pixel
// write on the dst channel against a cycle-free model of the blitter. The run
// starts with a table of hand-picked bytes, then random glyph streams at
// several screen sizes, with random gaps, random back-pressure and one long
// hold on the pixel side.
// ============================================================================
module testbench;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_CYCLES   = 200;
    localparam int SETTLE_CYCLES = 12;
    localparam int DRAIN_CYCLES  = 20;

    // Index that decodes to no register; writes to it must be ignored.
    localparam logic [gcx_pkg::CFG_INDEX_W-1:0] CFG_IDX_SPARE = 2'd3;

    typedef struct {
        logic                         first;
        logic [7:0]                   gbits;
        logic [7:0]                   mbits;
        logic                         usem;
        logic [gcx_pkg::POS_W-1:0]    top;
        logic [gcx_pkg::POS_W-1:0]    left;
        logic [gcx_pkg::DIM_W-1:0]    gw;
        logic [gcx_pkg::DIM_W-1:0]    gh;
        logic [gcx_pkg::COLOR_W-1:0]  fg;
        logic [gcx_pkg::COLOR_W-1:0]  bg;
        // Hand-written outcome for table rows: zero writes or one write.
        bit                           known;
        int                           known_n;
        logic [gcx_pkg::ADDR_W-1:0]   known_addr;
        logic [gcx_pkg::COLOR_W-1:0]  known_value;
    } src_byte_t;

    typedef struct packed {
        logic [gcx_pkg::ADDR_W-1:0]   addr;
        logic [gcx_pkg::COLOR_W-1:0]  value;
        logic                         last;
    } pixel_write_t;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_we;
    logic [gcx_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [gcx_pkg::CFG_DATA_W-1:0]  cfg_data;

    gcx_src_if src_ch ();
    gcx_dst_if dst_ch ();

    glyph_color_expansion_blit_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .src       (src_ch),
        .dst       (dst_ch)
    );

    // Model state: screen size registers and the glyph position counters.
    logic [gcx_pkg::SCREEN_W-1:0] scr_w;
    logic [gcx_pkg::SCREEN_W-1:0] scr_h;
    logic [gcx_pkg::ROW_W-1:0]    glyph_row;
    logic [gcx_pkg::BCOL_W-1:0]   glyph_bcol;

    pixel_write_t writes_due[$];
    pixel_write_t due_write;
    src_byte_t    offer;
    int           mismatches = 0;
    int           cycle_count = 0;
    int           src_idle_max = 4;
    int           dst_idle_max = 4;
    bit           hold_req = 1'b0;
    bit           hold_served = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("%0t: %s mismatch, got 0x%0h want 0x%0h", $time, what, got, want);
    endtask

    function automatic src_byte_t make_byte(input bit first, input logic [7:0] gbits,
                                            input logic [7:0] mbits, input bit usem,
                                            input logic [gcx_pkg::POS_W-1:0] top,
                                            input logic [gcx_pkg::POS_W-1:0] left,
                                            input logic [gcx_pkg::DIM_W-1:0] gw,
                                            input logic [gcx_pkg::DIM_W-1:0] gh,
                                            input logic [gcx_pkg::COLOR_W-1:0] fg,
                                            input logic [gcx_pkg::COLOR_W-1:0] bg);
        src_byte_t b;
        b.first = first;
        b.gbits = gbits;
        b.mbits = mbits;
        b.usem = usem;
        b.top = top;
        b.left = left;
        b.gw = gw;
        b.gh = gh;
        b.fg = fg;
        b.bg = bg;
        b.known = 1'b0;
        b.known_n = 0;
        b.known_addr = '0;
        b.known_value = '0;
        return b;
    endfunction

    function automatic src_byte_t with_known_writes(input src_byte_t b, input int n,
                                                    input logic [gcx_pkg::ADDR_W-1:0] addr,
                                                    input logic [gcx_pkg::COLOR_W-1:0] value);
        src_byte_t r;
        r = b;
        r.known = 1'b1;
        r.known_n = n;
        r.known_addr = addr;
        r.known_value = value;
        return r;
    endfunction

    // Expands one accepted source byte into the pixel writes it must cause and
    // advances the row and byte-column counters.
    function automatic void expand_source_byte(input src_byte_t b);
        pixel_write_t found[$];
        pixel_write_t w;
        int           nbytes;
        int           col;
        int unsigned  line;
        int unsigned  byte_addr;
        bit           emit;

        if (b.first)
        begin
            glyph_row = '0;
            glyph_bcol = '0;
        end

        if (int'(b.gw) == 0 || int'(b.gw) > int'(gcx_pkg::MAX_GLYPH_DIM) ||
            int'(b.gh) == 0 || int'(b.gh) > int'(gcx_pkg::MAX_GLYPH_DIM))
        begin
            glyph_row = '0;
            glyph_bcol = '0;
        end
        else
        begin
            emit = (int'(b.left) + int'(b.gw) <= int'(scr_w)) &&
                   (int'(b.top) + int'(b.gh) <= int'(scr_h)) &&
                   (int'(glyph_row) < int'(b.gh));
            if (emit)
            begin
                line = gcx_pkg::ROW_STRIDE_BYTES * (int'(b.top) + int'(glyph_row));
                for (int k = 0; k < 8; k++)
                begin
                    col = int'(glyph_bcol) * 8 + k;
                    if (col >= int'(b.gw))
                        break;
                    if (b.usem && !b.mbits[7-k])
                        continue;
                    byte_addr = line + gcx_pkg::PIX_BYTES * (int'(b.left) + col);
                    w.addr = byte_addr[gcx_pkg::ADDR_W-1:0];
                    w.value = b.gbits[7-k] ? b.fg : b.bg;
                    w.last = 1'b0;
                    found.push_back(w);
                end
                if (found.size() > 0)
                begin
                    w = found.pop_back();
                    w.last = 1'b1;
                    found.push_back(w);
                end
            end
            nbytes = (int'(b.gw) + 7) / 8;
            if (int'(glyph_bcol) + 1 >= nbytes)
            begin
                glyph_bcol = '0;
                glyph_row = glyph_row + 1'b1;
            end
            else
                glyph_bcol = glyph_bcol + 1'b1;
        end

        if (b.known)
        begin
            found.delete();
            if (b.known_n == 1)
            begin
                w.addr = b.known_addr;
                w.value = b.known_value;
                w.last = 1'b1;
                found.push_back(w);
            end
        end
        foreach (found[i])
            writes_due.push_back(found[i]);
    endfunction

    // Checks pixel beats, feeds accepted source bytes to the model and tracks
    // register writes. The pixel side is handled first so that a beat can
    // never be matched against a byte taken at the same edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (dst_ch.valid && dst_ch.ready)
            begin
                if (writes_due.size() == 0)
                    report_mismatch("unexpected pixel write, address",
                                    32'(dst_ch.pixel_address), 32'h0);
                else
                begin
                    due_write = writes_due.pop_front();
                    if (dst_ch.pixel_address !== due_write.addr)
                        report_mismatch("pixel_address", 32'(dst_ch.pixel_address),
                                        32'(due_write.addr));
                    if (dst_ch.pixel_value !== due_write.value)
                        report_mismatch("pixel_value", dst_ch.pixel_value,
                                        due_write.value);
                    if (dst_ch.last_of_byte !== due_write.last)
                        report_mismatch("last_of_byte", 32'(dst_ch.last_of_byte),
                                        32'(due_write.last));
                end
            end
            if (src_ch.valid && src_ch.ready)
                expand_source_byte(offer);
            if (cfg_we)
            begin
                if (cfg_index == gcx_pkg::CFG_IDX_SCREEN_WIDTH)
                    scr_w = cfg_data;
                else if (cfg_index == gcx_pkg::CFG_IDX_SCREEN_HEIGHT)
                    scr_h = cfg_data;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Pixel side: a random wait before each beat, and one long hold when asked.
    initial
    begin : pixel_sink
        int gap;
        dst_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (hold_req && !hold_served)
            begin
                dst_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_served = 1'b1;
            end
            gap = $urandom_range(0, dst_idle_max);
            if (gap > 0)
            begin
                dst_ch.ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            dst_ch.ready = 1'b1;
            do
                @(posedge clk);
            while (!dst_ch.valid && !(hold_req && !hold_served));
            @(negedge clk);
        end
    end

    task automatic send_byte(input src_byte_t b);
        int gap;
        gap = $urandom_range(0, src_idle_max);
        if (gap > 0)
        begin
            src_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        offer = b;
        src_ch.first_of_glyph = b.first;
        src_ch.glyph_bits = b.gbits;
        src_ch.mask_bits = b.mbits;
        src_ch.use_mask = b.usem;
        src_ch.top_line = b.top;
        src_ch.left_column = b.left;
        src_ch.glyph_width = b.gw;
        src_ch.glyph_height = b.gh;
        src_ch.fg_color = b.fg;
        src_ch.bg_color = b.bg;
        src_ch.valid = 1'b1;
        do
            @(posedge clk);
        while (!src_ch.ready);
        @(negedge clk);
    endtask

    // One glyph, row by row. A broken glyph is cut short, runs past its last
    // row, or starts without the first-of-glyph mark.
    task automatic send_glyph(input bit broken, output int sent);
        int        gw;
        int        gh;
        int        nbytes;
        int        total;
        int        pick;
        bit        mark_first;
        bit        usem;
        logic [gcx_pkg::POS_W-1:0]   top;
        logic [gcx_pkg::POS_W-1:0]   left;
        logic [gcx_pkg::COLOR_W-1:0] fg;
        logic [gcx_pkg::COLOR_W-1:0] bg;

        pick = $urandom_range(0, 99);
        if (pick < 70)
            gw = $urandom_range(1, 16);
        else if (pick < 95)
            gw = $urandom_range(17, 40);
        else
            gw = $urandom_range(41, 64);
        nbytes = (gw + 7) / 8;
        gh = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 8) : $urandom_range(9, 64);
        if (gh * nbytes > 64)
            gh = 64 / nbytes;

        if (int'(scr_w) >= gw && int'(scr_h) >= gh && $urandom_range(0, 9) != 0)
        begin
            left = gcx_pkg::POS_W'($urandom_range(0, int'(scr_w) - gw));
            top = gcx_pkg::POS_W'($urandom_range(0, int'(scr_h) - gh));
        end
        else
        begin
            left = gcx_pkg::POS_W'($urandom);
            top = gcx_pkg::POS_W'($urandom);
        end
        fg = $urandom;
        bg = $urandom;
        usem = 1'($urandom);

        total = gh * nbytes;
        mark_first = 1'b1;
        if (broken)
        begin
            case ($urandom_range(0, 2))
                0: total = $urandom_range(1, total);
                1: total = total + $urandom_range(1, 3);
                default: mark_first = 1'b0;
            endcase
        end
        for (int k = 0; k < total; k++)
            send_byte(make_byte(mark_first && k == 0, 8'($urandom), 8'($urandom), usem,
                                top, left, gcx_pkg::DIM_W'(gw), gcx_pkg::DIM_W'(gh),
                                fg, bg));
        sent = total;
    endtask

    task automatic random_traffic(input int n_items);
        int count;
        int sent;
        int pick;
        count = 0;
        while (count < n_items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 12)
            begin
                send_byte(make_byte(1'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
                                    gcx_pkg::POS_W'($urandom), gcx_pkg::POS_W'($urandom),
                                    gcx_pkg::DIM_W'($urandom), gcx_pkg::DIM_W'($urandom),
                                    $urandom, $urandom));
                sent = 1;
            end
            else
                send_glyph(pick < 25, sent);
            count += sent;
        end
    endtask

    // Drops valid, waits for every due write and lets trailing bytes that
    // write nothing clear the classifier before the screen size changes.
    task automatic wait_idle();
        src_ch.valid = 1'b0;
        while (writes_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [gcx_pkg::CFG_INDEX_W-1:0] index,
                             input logic [gcx_pkg::CFG_DATA_W-1:0] data);
        cfg_we = 1'b1;
        cfg_index = index;
        cfg_data = data;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    initial
    begin : stimulus
        src_byte_t directed[$];

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        src_ch.valid = 1'b0;
        src_ch.first_of_glyph = 1'b0;
        src_ch.glyph_bits = '0;
        src_ch.mask_bits = '0;
        src_ch.use_mask = 1'b0;
        src_ch.top_line = '0;
        src_ch.left_column = '0;
        src_ch.glyph_width = '0;
        src_ch.glyph_height = '0;
        src_ch.fg_color = '0;
        src_ch.bg_color = '0;
        scr_w = gcx_pkg::SCREEN_WIDTH_RST;
        scr_h = gcx_pkg::SCREEN_HEIGHT_RST;
        glyph_row = '0;
        glyph_bcol = '0;

        // Screen is 1024 x 768 out of reset.
        // Single pixels in the top left and bottom right corners.
        directed.push_back(with_known_writes(make_byte(1'b1, 8'h80, 8'h00, 1'b0,
            11'd0, 11'd0, 7'd1, 7'd1, 32'hFFFF_FFFF, 32'h0), 1, 24'd0, 32'hFFFF_FFFF));
        directed.push_back(with_known_writes(make_byte(1'b1, 8'h7F, 8'hFF, 1'b1,
            11'd767, 11'd1023, 7'd1, 7'd1, 32'hA5A5_A5A5, 32'h1234_5678),
            1, 24'd6287356, 32'h1234_5678));
        // Off the bottom, off the right, and off both with every position bit set.
        directed.push_back(with_known_writes(make_byte(1'b1, 8'hFF, 8'hFF, 1'b0,
            11'd768, 11'd0, 7'd1, 7'd1, 32'h1, 32'h2), 0, '0, '0));
        directed.push_back(with_known_writes(make_byte(1'b1, 8'hFF, 8'hFF, 1'b0,
            11'd0, 11'd1024, 7'd1, 7'd1, 32'h1, 32'h2), 0, '0, '0));
        directed.push_back(with_known_writes(make_byte(1'b1, 8'hFF, 8'hFF, 1'b0,
            11'd2047, 11'd2047, 7'd64, 7'd64, 32'h1, 32'h2), 0, '0, '0));
        // Bad sizes: zero and above the largest glyph.
        directed.push_back(with_known_writes(make_byte(1'b1, 8'hFF, 8'hFF, 1'b0,
            11'd0, 11'd0, 7'd0, 7'd8, 32'h1, 32'h2), 0, '0, '0));
        directed.push_back(with_known_writes(make_byte(1'b1, 8'hFF, 8'hFF, 1'b0,
            11'd0, 11'd0, 7'd65, 7'd8, 32'h1, 32'h2), 0, '0, '0));
        directed.push_back(with_known_writes(make_byte(1'b1, 8'hFF, 8'hFF, 1'b0,
            11'd0, 11'd0, 7'd8, 7'd0, 32'h1, 32'h2), 0, '0, '0));
        directed.push_back(with_known_writes(make_byte(1'b1, 8'hFF, 8'hFF, 1'b0,
            11'd0, 11'd0, 7'd127, 7'd127, 32'h1, 32'h2), 0, '0, '0));
        // Every pixel masked off.
        directed.push_back(with_known_writes(make_byte(1'b1, 8'hFF, 8'h00, 1'b1,
            11'd5, 11'd5, 7'd8, 7'd1, 32'h1, 32'h2), 0, '0, '0));
        // Two rows, then a byte past the last row.
        directed.push_back(make_byte(1'b1, 8'hA5, 8'hFF, 1'b1,
            11'd10, 11'd20, 7'd8, 7'd2, 32'hDEAD_BEEF, 32'h0BAD_F00D));
        directed.push_back(make_byte(1'b0, 8'h5A, 8'h0F, 1'b1,
            11'd10, 11'd20, 7'd8, 7'd2, 32'hDEAD_BEEF, 32'h0BAD_F00D));
        directed.push_back(make_byte(1'b0, 8'hFF, 8'hFF, 1'b0,
            11'd10, 11'd20, 7'd8, 7'd2, 32'hDEAD_BEEF, 32'h0BAD_F00D));
        // Twelve wide: the second byte of the first row stops at the glyph width.
        directed.push_back(make_byte(1'b1, 8'hFF, 8'h00, 1'b0,
            11'd100, 11'd1000, 7'd12, 7'd2, 32'h00FF_00FF, 32'hFF00_FF00));
        directed.push_back(make_byte(1'b0, 8'h0F, 8'h00, 1'b0,
            11'd100, 11'd1000, 7'd12, 7'd2, 32'h00FF_00FF, 32'hFF00_FF00));
        directed.push_back(make_byte(1'b0, 8'h00, 8'h00, 1'b0,
            11'd100, 11'd1000, 7'd12, 7'd2, 32'h00FF_00FF, 32'hFF00_FF00));
        // Largest glyph flush against the right edge.
        directed.push_back(make_byte(1'b1, 8'hC3, 8'h3C, 1'b1,
            11'd0, 11'd960, 7'd64, 7'd64, 32'h7777_7777, 32'h8888_8888));
        directed.push_back(make_byte(1'b0, 8'h3C, 8'hC3, 1'b1,
            11'd0, 11'd960, 7'd64, 7'd64, 32'h7777_7777, 32'h8888_8888));
        // A bad size in mid glyph clears the counters; a new first mark does too.
        directed.push_back(make_byte(1'b1, 8'h81, 8'h00, 1'b0,
            11'd700, 11'd0, 7'd8, 7'd4, 32'h1111_1111, 32'h2222_2222));
        directed.push_back(make_byte(1'b0, 8'h81, 8'h00, 1'b0,
            11'd700, 11'd0, 7'd0, 7'd4, 32'h1111_1111, 32'h2222_2222));
        directed.push_back(make_byte(1'b0, 8'h42, 8'h00, 1'b0,
            11'd700, 11'd0, 7'd8, 7'd4, 32'h1111_1111, 32'h2222_2222));
        directed.push_back(make_byte(1'b0, 8'h24, 8'h00, 1'b0,
            11'd700, 11'd0, 7'd8, 7'd4, 32'h1111_1111, 32'h2222_2222));
        directed.push_back(make_byte(1'b1, 8'h18, 8'h00, 1'b0,
            11'd700, 11'd0, 7'd8, 7'd4, 32'h1111_1111, 32'h2222_2222));

        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed[i])
            send_byte(directed[i]);

        // Bytes keep coming after a one-row glyph: the row counter wraps after
        // 64 bytes and the glyph paints again.
        src_idle_max = 0;
        for (int k = 0; k < 65; k++)
            send_byte(make_byte(k == 0, 8'($urandom), 8'hFF, 1'b0, 11'd3, 11'd7,
                                7'd1, 7'd1, 32'hCAFE_0001, 32'hCAFE_0000));

        // A 2047 x 2047 screen, no idling, and one long hold on the pixel side.
        wait_idle();
        write_reg(gcx_pkg::CFG_IDX_SCREEN_WIDTH, 12'd2047);
        write_reg(gcx_pkg::CFG_IDX_SCREEN_HEIGHT, 12'd2047);
        dst_idle_max = 0;
        hold_req = 1'b1;
        send_byte(make_byte(1'b1, 8'hFF, 8'h00, 1'b0, 11'd2046, 11'd2046, 7'd1, 7'd1,
                            32'h5555_AAAA, 32'hAAAA_5555));
        random_traffic(60);

        // Smallest screen: only a one-pixel glyph at the origin fits.
        wait_idle();
        write_reg(gcx_pkg::CFG_IDX_SCREEN_WIDTH, 12'd1);
        write_reg(gcx_pkg::CFG_IDX_SCREEN_HEIGHT, 12'd1);
        src_idle_max = 4;
        dst_idle_max = 4;
        random_traffic(30);

        // Random size; the spare index must leave both registers alone.
        wait_idle();
        write_reg(gcx_pkg::CFG_IDX_SCREEN_WIDTH,
                  gcx_pkg::CFG_DATA_W'($urandom_range(1, 2048)));
        write_reg(gcx_pkg::CFG_IDX_SCREEN_HEIGHT,
                  gcx_pkg::CFG_DATA_W'($urandom_range(1, 2048)));
        write_reg(CFG_IDX_SPARE, 12'd5);
        random_traffic(60);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
